/* sv/lcdseq_pkg.sv */
// Shared types, request codes and the microcode table for the LCD nibble sequencer.
// No dependencies.
`timescale 1ns / 1ps

package lcdseq_pkg;

    // request kinds carried in tuser of the input stream
    localparam logic [1:0] REQ_INIT   = 2'd0;
    localparam logic [1:0] REQ_CHAR   = 2'd1;
    localparam logic [1:0] REQ_POS    = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // character codes with special handling
    localparam logic [7:0] CODE_CLEAR    = 8'd8;
    localparam logic [7:0] CODE_NEWLINE  = 8'd10;
    localparam logic [7:0] CODE_FORMFEED = 8'd12;

    localparam logic [7:0] CMD_CLEAR = 8'h01;
    localparam logic       CMD_DDRAM = 1'b1;   // bit 7 of the set-address command
    localparam logic       ROW2_BIT  = 1'b1;   // second line base is 64

    localparam int         UC_DEPTH = 16;
    localparam int         UC_AW    = $clog2(UC_DEPTH);

    // microcode entry points
    localparam logic [UC_AW-1:0] UC_INIT = 4'd0;
    localparam logic [UC_AW-1:0] UC_BYTE = 4'd14;

    typedef enum logic [1:0] {
        SRC_CONST = 2'd0,
        SRC_HI    = 2'd1,
        SRC_LO    = 2'd2
    } t_nib_src;

    typedef struct packed {
        t_nib_src         src;
        logic [3:0]       nib;
        logic             last;   // end of program: stop, else jump to next
        logic [UC_AW-1:0] next;
    } t_uword;

    typedef struct packed {
        logic             go;
        logic [UC_AW-1:0] entry;
        logic [7:0]       byte_val;
        logic             rs;
    } t_dec;

    function automatic t_uword uc_rom(input logic [UC_AW-1:0] pc);
        t_uword w;
        w = '{src: SRC_CONST, nib: 4'h0, last: 1'b0, next: pc + 4'd1};
        unique case (pc)
            4'd0:  w.nib = 4'h3;
            4'd1:  w.nib = 4'h3;
            4'd2:  w.nib = 4'h3;
            4'd3:  w.nib = 4'h2;
            4'd4:  w.nib = 4'h2;
            4'd5:  w.nib = 4'hF;
            4'd6:  w.nib = 4'h0;
            4'd7:  w.nib = 4'h8;
            4'd8:  w.nib = 4'h0;
            4'd9:  w.nib = 4'h1;
            4'd10: w.nib = 4'h0;
            4'd11: w.nib = 4'h6;
            4'd12: w.nib = 4'h0;
            4'd13: begin
                w.nib  = 4'hC;
                w.last = 1'b1;
                w.next = UC_INIT;
            end
            4'd14: w.src = SRC_HI;
            4'd15: begin
                w.src  = SRC_LO;
                w.last = 1'b1;
                w.next = UC_INIT;
            end
            default: w = '{src: SRC_CONST, nib: 4'h0, last: 1'b1, next: UC_INIT};
        endcase
        return w;
    endfunction

endpackage

/* sv/char_lcd_nibble_command_sequencer_core.sv */
// Top level of the LCD nibble sequencer: request intake, microcode step counter, output register.
// Depends on lcdseq_pkg and lcdseq_decode.
`timescale 1ns / 1ps

// Usage:
//   The slave stream takes one request per handshake: tuser carries the request
//   kind (init, character, cursor position), tdata the character, column and row.
//   The master stream gives one nibble per handshake, each standing for one enable
//   strobe: tdata holds DB7..DB4, tuser the register-select bit, tlast marks the
//   final nibble of the request's run.
//   A microcode program in a read-only table drives the output: one step per cycle,
//   set by the step counter, unless the receiver stalls. An init request runs 14
//   steps, a character, clear or position request 2 steps; ignored requests run none.
//   An accepted request loads the step counter; its first step then loads the
//   output register. No new request is taken while a run is in progress.
//   A new request is taken once the last nibble is loaded, even if it still waits.
//   When the receiver stalls, the output register holds and the step counter waits.
//   Reset (synchronous, active low) stops any run and empties the output register.
//   Pin timing and display delays are outside this block.
module char_lcd_nibble_command_sequencer_core
    import lcdseq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] char_code, [13:8] column, [14] row, [15] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [3:0] nibble, [7:4] zero
    output logic        o_m_tuser,   // [0] register_select
    output logic        o_m_tlast    // last
);

    logic             r_run, n_run;
    logic [UC_AW-1:0] r_pc, n_pc;
    logic [7:0]       r_byte;
    logic             r_rs;
    logic             r_out_valid, n_out_valid;
    logic [3:0]       r_nib;
    logic             r_out_rs;
    logic             r_out_last;

    t_dec             dec;
    t_uword           uw;
    logic             accept;
    logic             step;
    logic [3:0]       nib_sel;

    lcdseq_decode u_decode (
        .i_req_type  (i_s_tuser),
        .i_char_code (i_s_tdata[7:0]),
        .i_column    (i_s_tdata[13:8]),
        .i_row       (i_s_tdata[14]),
        .o_dec       (dec)
    );

    assign o_s_tready = !r_run;
    assign accept     = i_s_tvalid && o_s_tready;
    // advance only when the output register is free or being emptied
    assign step       = r_run && (!r_out_valid || i_m_tready);
    assign uw         = uc_rom(r_pc);

    always_comb begin
        unique case (uw.src)
            SRC_HI:  nib_sel = r_byte[7:4];
            SRC_LO:  nib_sel = r_byte[3:0];
            default: nib_sel = uw.nib;
        endcase
    end

    always_comb begin
        n_run       = r_run;
        n_pc        = r_pc;
        n_out_valid = r_out_valid;
        if (accept && dec.go) begin
            n_run = 1'b1;
            n_pc  = dec.entry;
        end
        if (step) begin
            n_out_valid = 1'b1;
            // end of program drops the run, else take the jump target
            if (uw.last) begin
                n_run = 1'b0;
            end else begin
                n_pc = uw.next;
            end
        end else if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= 1'b0;
            r_pc        <= UC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_run       <= n_run;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    // payload: hold the request byte for the run, load the output on each step
    always_ff @(posedge i_clk) begin
        if (accept && dec.go) begin
            r_byte <= dec.byte_val;
            r_rs   <= dec.rs;
        end
        if (step) begin
            r_nib      <= nib_sel;
            r_out_rs   <= r_rs;
            r_out_last <= uw.last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_nib};
    assign o_m_tuser  = r_out_rs;
    assign o_m_tlast  = r_out_last;

endmodule

/* sv/lcdseq_decode.sv */
// Request decoder: picks the microcode entry point and builds the byte and RS value.
// Depends on lcdseq_pkg.
`timescale 1ns / 1ps

module lcdseq_decode
    import lcdseq_pkg::*;
(
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_char_code,
    input  logic [5:0] i_column,
    input  logic       i_row,
    output t_dec       o_dec
);

    logic [6:0] addr;

    // 7-bit wrap is intended: column zero folds to the address below the row base, modulo 128
    assign addr = {i_row & ROW2_BIT, 6'd0} + {1'b0, i_column} - 7'd1;

    always_comb begin
        o_dec = '{go: 1'b0, entry: UC_BYTE, byte_val: i_char_code, rs: 1'b1};
        unique case (i_req_type)
            REQ_INIT: begin
                o_dec.go    = 1'b1;
                o_dec.entry = UC_INIT;
                o_dec.rs    = 1'b0;
            end
            REQ_CHAR: begin
                priority if (i_char_code == CODE_NEWLINE || i_char_code == CODE_FORMFEED) begin
                    o_dec.go = 1'b0;
                end else if (i_char_code == CODE_CLEAR) begin
                    o_dec.go       = 1'b1;
                    o_dec.byte_val = CMD_CLEAR;
                    o_dec.rs       = 1'b0;
                end else begin
                    o_dec.go = 1'b1;
                end
            end
            REQ_POS: begin
                o_dec.go       = 1'b1;
                o_dec.byte_val = {CMD_DDRAM, addr};
                o_dec.rs       = 1'b0;
            end
            default: o_dec.go = 1'b0;
        endcase
    end

endmodule

/* sv/lcdseq_checker.sv */
// Port-level checker for the LCD nibble sequencer, bound to the top level.
// Depends on lcdseq_pkg and char_lcd_nibble_command_sequencer_core.
`timescale 1ns / 1ps

module lcdseq_checker
    import lcdseq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [1:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [7:0]  o_m_tdata,
    input logic        o_m_tuser,
    input logic        o_m_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // an init request keeps the sequencer busy
    a_init_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == REQ_INIT |=> !o_s_tready)
        else $error("init request did not start a run");

    // an unused request kind starts nothing
    a_unused_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == REQ_UNUSED |=> o_s_tready)
        else $error("unused request kind started a run");

    // reset empties the output and frees the input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("reset did not clear the sequencer");

    // the padding above the nibble stays zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[7:4] == 4'd0)
        else $error("nibble padding not zero");

endmodule

bind char_lcd_nibble_command_sequencer_core lcdseq_checker u_lcdseq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
